// ===== src/nsfp_pkg.sv =====
// Shared types, constants and lookup tables for the NMEA sentence field parser.
// No dependencies; every other file refers to this package by scoped names.
package nsfp_pkg;

   localparam int FRAC_DIGITS_DEFAULT     = 5;
   localparam int MAX_FIELD_CHARS_DEFAULT = 24;

   // Magnitude of a parsed number, already scaled.
   localparam int MAG_W = 47;
   localparam int VAL_W = 48;
   localparam int ACC_W = 51;
   localparam logic [MAG_W-1:0] VALUE_LIMIT    = 47'd99999999999999;
   localparam logic [MAG_W-1:0] VALUE_LIMIT_P1 = 47'd100000000000000;

   localparam int SLOT_COUNT  = 12;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] KIND_UNKNOWN = 3'd7;
   localparam logic [4:0] FIELD_NUM_MAX = 5'd31;
   localparam logic [2:0] CHAR_POS_MAX  = 3'd6;
   localparam logic [2:0] POS_TYPE_HI   = 3'd3;
   localparam logic [2:0] POS_TYPE_LO   = 3'd4;
   localparam logic [2:0] POS_TYPE_END  = 3'd5;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_POINT   = 8'h2E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   typedef enum logic [1:0] {
      QT_REAL,
      QT_INT,
      QT_CHAR
   } qty_class_type;

   typedef enum logic [1:0] {
      OP_CHAR,
      OP_COMMA,
      OP_END
   } op_kind_type;

   // One classified byte handed from the front to the back.
   typedef struct packed {
      op_kind_type   op;
      logic [7:0]    ch;
      logic          first;
      logic          emit;
      logic [2:0]    kind;
      logic [4:0]    qcode;
      qty_class_type qclass;
   } byte_op_type;

   // Quantity code plus one per kind and field number, zero when not recorded.
   localparam logic [4:0] SLOT_MAP [0:6][0:SLOT_COUNT-1] = '{
      '{5'd0, 5'd1,  5'd2,  5'd3,  5'd4, 5'd5, 5'd6, 5'd7,  5'd8,  5'd9, 5'd0,  5'd0},
      '{5'd0, 5'd1,  5'd10, 5'd2,  5'd3, 5'd4, 5'd5, 5'd11, 5'd12, 5'd0, 5'd13, 5'd14},
      '{5'd0, 5'd2,  5'd3,  5'd4,  5'd5, 5'd10, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0},
      '{5'd0, 5'd15, 5'd16, 5'd11, 5'd17, 5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0},
      '{5'd0, 5'd18, 5'd0,  5'd0,  5'd0, 5'd0, 5'd0, 5'd0,  5'd0,  5'd0, 5'd0,  5'd0},
      '{5'd0, 5'd0,  5'd19, 5'd20, 5'd0, 5'd0, 5'd0, 5'd0,  5'd0,  5'd0, 5'd0,  5'd0},
      '{5'd0, 5'd21, 5'd22, 5'd23, 5'd24, 5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0}
   };

   localparam qty_class_type QTY_CLASS [0:23] = '{
      QT_INT,  QT_REAL, QT_CHAR, QT_REAL, QT_CHAR, QT_INT,
      QT_INT,  QT_REAL, QT_REAL, QT_CHAR, QT_REAL, QT_REAL,
      QT_REAL, QT_CHAR, QT_REAL, QT_REAL, QT_REAL, QT_CHAR,
      QT_INT,  QT_INT,  QT_INT,  QT_INT,  QT_INT,  QT_INT
   };

   function automatic logic [23:0] pow_ten(input logic [2:0] n);
      logic [23:0] p;
      case (n)
         3'd0:    p = 24'd1;
         3'd1:    p = 24'd10;
         3'd2:    p = 24'd100;
         3'd3:    p = 24'd1000;
         3'd4:    p = 24'd10000;
         3'd5:    p = 24'd100000;
         3'd6:    p = 24'd1000000;
         default: p = 24'd10000000;
      endcase
      return p;
   endfunction

   // Match the three type letters against the known sentence kinds.
   function automatic logic [2:0] decide_kind(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
      logic [23:0] t;
      logic [2:0]  k;
      t = {a, b, c};
      case (t)
         "GGA":   k = 3'd0;
         "RMC":   k = 3'd1;
         "GLL":   k = 3'd2;
         "VTG":   k = 3'd3;
         "GSA":   k = 3'd4;
         "GSV":   k = 3'd5;
         "ZDA":   k = 3'd6;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

// ===== src/nsfp_front.sv =====
// Front end of the NMEA field parser: accepts bytes, tracks sentence kind and field
// positions, and classifies each byte into an operation. Uses nsfp_pkg.
module nsfp_front #(
   parameter int MAX_FIELD_CHARS = nsfp_pkg::MAX_FIELD_CHARS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   input  logic                q_full,
   output logic                q_push,
   output nsfp_pkg::byte_op_type q_entry
);

   logic [2:0]  pos_ff, pos_in;
   logic [2:0]  kind_ff, kind_in;
   logic [15:0] type_ff, type_in;
   logic [4:0]  field_num_ff, field_num_in;
   logic [4:0]  field_len_ff, field_len_in;
   logic        accept;
   logic [4:0]  slot;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pos_in       = pos_ff;
      kind_in      = kind_ff;
      type_in      = type_ff;
      field_num_in = field_num_ff;
      field_len_in = field_len_ff;
      slot         = 5'd0;
      q_push       = 1'b0;
      q_entry      = '0;
      q_entry.ch   = req_rx_byte;

      if (req_rx_byte == nsfp_pkg::CH_NEWLINE || req_rx_byte == nsfp_pkg::CH_NUL) begin
         // end of sentence: rearm everything
         pos_in       = 3'd0;
         kind_in      = nsfp_pkg::KIND_UNKNOWN;
         type_in      = 16'd0;
         field_num_in = 5'd0;
         field_len_in = 5'd0;
         q_push       = accept;
         q_entry.op   = nsfp_pkg::OP_END;
         q_entry.ch   = 8'd0;
      end else begin
         if (pos_ff == nsfp_pkg::POS_TYPE_HI) begin
            type_in[15:8] = req_rx_byte;
         end else if (pos_ff == nsfp_pkg::POS_TYPE_LO) begin
            type_in[7:0] = req_rx_byte;
         end else if (pos_ff == nsfp_pkg::POS_TYPE_END) begin
            kind_in = nsfp_pkg::decide_kind(type_ff[15:8], type_ff[7:0], req_rx_byte);
         end
         if (pos_ff < nsfp_pkg::CHAR_POS_MAX) begin
            pos_in = pos_ff + 3'd1;
         end

         if (req_rx_byte == nsfp_pkg::CH_COMMA) begin
            if (kind_in != nsfp_pkg::KIND_UNKNOWN &&
                field_num_ff < 5'(nsfp_pkg::SLOT_COUNT)) begin
               slot = nsfp_pkg::SLOT_MAP[kind_in][field_num_ff[3:0]];
            end
            q_push         = accept;
            q_entry.op     = nsfp_pkg::OP_COMMA;
            q_entry.emit   = (slot != 5'd0);
            q_entry.kind   = kind_in;
            q_entry.qcode  = slot - 5'd1;
            q_entry.qclass = (slot != 5'd0) ? nsfp_pkg::QTY_CLASS[slot - 5'd1]
                                            : nsfp_pkg::QT_CHAR;
            field_len_in   = 5'd0;
            if (field_num_ff < nsfp_pkg::FIELD_NUM_MAX) begin
               field_num_in = field_num_ff + 5'd1;
            end
         end else if (field_len_ff < 5'(MAX_FIELD_CHARS)) begin
            // characters past the field limit are dropped here
            q_push        = accept;
            q_entry.op    = nsfp_pkg::OP_CHAR;
            q_entry.first = (field_len_ff == 5'd0);
            field_len_in  = field_len_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 3'd0;
         kind_ff      <= nsfp_pkg::KIND_UNKNOWN;
         type_ff      <= 16'd0;
         field_num_ff <= 5'd0;
         field_len_ff <= 5'd0;
      end else if (accept) begin
         pos_ff       <= pos_in;
         kind_ff      <= kind_in;
         type_ff      <= type_in;
         field_num_ff <= field_num_in;
         field_len_ff <= field_len_in;
      end
   end

endmodule

// ===== src/nsfp_queue.sv =====
// Short FIFO of classified byte operations between front and back of the parser.
// Uses nsfp_pkg for the entry type and depth.
module nsfp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  nsfp_pkg::byte_op_type push_entry,
   output logic                  full,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output nsfp_pkg::byte_op_type pop_entry
);

   localparam int PtrW = (nsfp_pkg::QUEUE_DEPTH > 1) ? $clog2(nsfp_pkg::QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(nsfp_pkg::QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(nsfp_pkg::QUEUE_DEPTH - 1);

   nsfp_pkg::byte_op_type mem_ff [nsfp_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            pop;

   assign full      = (count_ff == CntW'(nsfp_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

endmodule

// ===== src/nsfp_back.sv =====
// Back end of the NMEA field parser: runs the number accumulator on field bytes and
// builds results into the output register. Uses nsfp_pkg.
module nsfp_back #(
   parameter int FRAC_DIGITS = nsfp_pkg::FRAC_DIGITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  nsfp_pkg::byte_op_type         q_entry,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_sentence_kind,
   output logic [4:0]                    rsp_quantity_code,
   output logic signed [nsfp_pkg::VAL_W-1:0] rsp_scaled_value,
   output logic [7:0]                    rsp_first_char,
   output logic                          rsp_end_of_sentence
);

   localparam int MagW = nsfp_pkg::MAG_W;
   localparam int AccW = nsfp_pkg::ACC_W;
   localparam logic [2:0]      FracMax   = 3'(FRAC_DIGITS);
   localparam logic [2:0]      FracTop   = 3'(FRAC_DIGITS - 1);
   localparam logic [23:0]     IntScale  = nsfp_pkg::pow_ten(3'(FRAC_DIGITS));
   localparam logic [MagW-1:0] LimitTrunc =
      nsfp_pkg::VALUE_LIMIT_P1 - MagW'(IntScale);

   logic [MagW-1:0] acc_ff, acc_in;
   logic [MagW-1:0] trunc_ff, trunc_in;
   logic [2:0]      frac_cnt_ff, frac_cnt_in;
   logic            neg_ff, neg_in, point_ff, point_in;
   logic            stop_ff, stop_in, start_ff, start_in;
   logic [7:0]      first_ff, first_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      kind_ff, kind_in;
   logic [4:0]      qcode_ff, qcode_in;
   logic [nsfp_pkg::VAL_W-1:0] value_ff, value_in;
   logic [7:0]      rsp_char_ff, rsp_char_in;
   logic            eos_ff, eos_in;

   logic            out_free, pop, is_digit;
   logic [3:0]      digit;
   logic [AccW-1:0] sum;
   logic [MagW-1:0] sat_sum, mag;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_ready  = out_free;
   assign pop      = q_valid && out_free;

   assign is_digit = (q_entry.ch >= nsfp_pkg::CH_ZERO) && (q_entry.ch <= nsfp_pkg::CH_NINE);
   assign digit    = q_entry.ch[3:0];

   // integer digits shift the value up; fraction digits add at their weight
   always_comb begin
      if (!point_ff) begin
         sum = AccW'({acc_ff, 3'b000}) + AccW'({acc_ff, 1'b0}) +
               AccW'(digit) * AccW'(IntScale);
      end else begin
         sum = AccW'(acc_ff) + AccW'(digit * nsfp_pkg::pow_ten(FracTop - frac_cnt_ff));
      end
      sat_sum = (sum > AccW'(nsfp_pkg::VALUE_LIMIT)) ? nsfp_pkg::VALUE_LIMIT : MagW'(sum);
   end

   always_comb begin
      case (q_entry.qclass)
         nsfp_pkg::QT_REAL: mag = acc_ff;
         nsfp_pkg::QT_INT:  mag = trunc_ff;
         default:           mag = '0;
      endcase
   end

   always_comb begin
      acc_in      = acc_ff;
      trunc_in    = trunc_ff;
      frac_cnt_in = frac_cnt_ff;
      neg_in      = neg_ff;
      point_in    = point_ff;
      stop_in     = stop_ff;
      start_in    = start_ff;
      first_in    = first_ff;

      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      qcode_in     = qcode_ff;
      value_in     = value_ff;
      rsp_char_in  = rsp_char_ff;
      eos_in       = eos_ff;

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      if (pop) begin
         case (q_entry.op)
            nsfp_pkg::OP_CHAR: begin
               if (q_entry.first) begin
                  first_in = q_entry.ch;
               end
               if (!stop_ff) begin
                  if ((q_entry.ch == nsfp_pkg::CH_MINUS || q_entry.ch == nsfp_pkg::CH_PLUS)
                      && !start_ff) begin
                     neg_in   = (q_entry.ch == nsfp_pkg::CH_MINUS);
                     start_in = 1'b1;
                  end else if (is_digit) begin
                     start_in = 1'b1;
                     if (!point_ff) begin
                        acc_in   = sat_sum;
                        trunc_in = (sat_sum == nsfp_pkg::VALUE_LIMIT) ? LimitTrunc : sat_sum;
                     end else if (frac_cnt_ff < FracMax) begin
                        acc_in      = sat_sum;
                        frac_cnt_in = frac_cnt_ff + 3'd1;
                        if (sat_sum == nsfp_pkg::VALUE_LIMIT) begin
                           trunc_in = LimitTrunc;
                        end
                     end
                  end else if (q_entry.ch == nsfp_pkg::CH_POINT && !point_ff) begin
                     point_in = 1'b1;
                     start_in = 1'b1;
                  end else begin
                     stop_in = 1'b1;
                  end
               end
            end
            nsfp_pkg::OP_COMMA: begin
               rsp_valid_in = q_entry.emit;
               kind_in      = q_entry.kind;
               qcode_in     = q_entry.qcode;
               value_in     = neg_ff ? -{1'b0, mag} : {1'b0, mag};
               rsp_char_in  = first_ff;
               eos_in       = 1'b0;
            end
            nsfp_pkg::OP_END: begin
               rsp_valid_in = 1'b1;
               kind_in      = 3'd0;
               qcode_in     = 5'd0;
               value_in     = '0;
               rsp_char_in  = 8'd0;
               eos_in       = 1'b1;
            end
            default: begin
            end
         endcase

         // a closed field or sentence starts the next field from scratch
         if (q_entry.op == nsfp_pkg::OP_COMMA || q_entry.op == nsfp_pkg::OP_END) begin
            acc_in      = '0;
            trunc_in    = '0;
            frac_cnt_in = 3'd0;
            neg_in      = 1'b0;
            point_in    = 1'b0;
            stop_in     = 1'b0;
            start_in    = 1'b0;
            first_in    = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         trunc_ff     <= '0;
         frac_cnt_ff  <= 3'd0;
         neg_ff       <= 1'b0;
         point_ff     <= 1'b0;
         stop_ff      <= 1'b0;
         start_ff     <= 1'b0;
         first_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         trunc_ff     <= trunc_in;
         frac_cnt_ff  <= frac_cnt_in;
         neg_ff       <= neg_in;
         point_ff     <= point_in;
         stop_ff      <= stop_in;
         start_ff     <= start_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      qcode_ff    <= qcode_in;
      value_ff    <= value_in;
      rsp_char_ff <= rsp_char_in;
      eos_ff      <= eos_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sentence_kind   = kind_ff;
   assign rsp_quantity_code   = qcode_ff;
   assign rsp_scaled_value    = $signed(value_ff);
   assign rsp_first_char      = rsp_char_ff;
   assign rsp_end_of_sentence = eos_ff;

endmodule

// ===== src/nmea_sentence_field_parser.sv =====
// NMEA 0183 sentence field parser, top level: front classifier, queue, back end.
// Depends on nsfp_pkg, nsfp_front, nsfp_queue and nsfp_back.
//
// Feed the sentence one character per word on req_; the block takes one word every
// clock cycle while its queue has room and returns, through the queue and the output
// register, one rsp_ word for every comma that closes a recorded field of a GGA,
// RMC, GLL, VTG, GSA, GSV or ZDA sentence, and one end marker (rsp_end_of_sentence
// high, all else zero) for a newline or NUL, which also rearms the parser. The front
// end decides the sentence kind from bytes 3 to 5 and looks up the quantity code; a
// two-entry queue carries the classified byte to the back end, whose multiply-by-ten
// accumulator builds the value scaled by 10^FRAC_DIGITS, saturating at
// +/-99999999999999. The rate of one byte per cycle is set by that accumulator's
// single add-and-saturate step; a stalled output lets the queue fill, and a full queue
// drops req_ready. Fields longer than MAX_FIELD_CHARS keep only their leading
// characters; the last field of a sentence and its checksum produce nothing.
module nmea_sentence_field_parser #(
   parameter int FRAC_DIGITS     = nsfp_pkg::FRAC_DIGITS_DEFAULT,
   parameter int MAX_FIELD_CHARS = nsfp_pkg::MAX_FIELD_CHARS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_sentence_kind,
   output logic [4:0]                        rsp_quantity_code,
   output logic signed [nsfp_pkg::VAL_W-1:0] rsp_scaled_value,
   output logic [7:0]                        rsp_first_char,
   output logic                              rsp_end_of_sentence
);

   localparam logic signed [nsfp_pkg::VAL_W-1:0] LimitPos =
      $signed({1'b0, nsfp_pkg::VALUE_LIMIT});
   localparam logic signed [nsfp_pkg::VAL_W-1:0] LimitNeg = -LimitPos;

   logic                  q_full, q_push, q_valid, q_ready;
   nsfp_pkg::byte_op_type push_entry, pop_entry;

   // classify bytes and track sentence position
   nsfp_front #(
      .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_rx_byte(req_rx_byte),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   // decouple front and back
   nsfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(push_entry),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_ready (q_ready),
      .pop_entry (pop_entry)
   );

   // accumulate numbers and drive results
   nsfp_back #(
      .FRAC_DIGITS(FRAC_DIGITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_ready            (q_ready),
      .q_entry            (pop_entry),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sentence_kind  (rsp_sentence_kind),
      .rsp_quantity_code  (rsp_quantity_code),
      .rsp_scaled_value   (rsp_scaled_value),
      .rsp_first_char     (rsp_first_char),
      .rsp_end_of_sentence(rsp_end_of_sentence)
   );

   // an end marker carries nothing else
   a_end_marker_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_sentence |->
         rsp_sentence_kind == 3'd0 && rsp_quantity_code == 5'd0 &&
         rsp_scaled_value == '0 && rsp_first_char == 8'd0)
      else $error("end marker with nonzero payload");

   // field results come from a known kind and a real quantity
   a_field_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_sentence |->
         rsp_sentence_kind != nsfp_pkg::KIND_UNKNOWN && rsp_quantity_code < 5'd24)
      else $error("field result with bad kind or quantity code");

   // the value never leaves the saturation range
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_scaled_value <= LimitPos && rsp_scaled_value >= LimitNeg)
      else $error("scaled value outside saturation range");

   // the queue never takes a word it has no room for
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue overflow");

endmodule

// ===== tb/tb_nmea_sentence_field_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nmea_sentence_field_parser: drives NMEA text, predicts each word.
// Depends on nsfp_pkg for character constants, quantity classes and the value limit.
module tb_nmea_sentence_field_parser;

   localparam int FRAC_DIGITS     = nsfp_pkg::FRAC_DIGITS_DEFAULT;
   localparam int MAX_FIELD_CHARS = nsfp_pkg::MAX_FIELD_CHARS_DEFAULT;
   localparam int FIELD_SLOTS     = 12;
   localparam int FIELD_NUM_TOP   = 31;
   localparam int POS_TOP         = 6;
   localparam int RANDOM_ITEMS    = 1450;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int TAIL_CYCLES     = 16;
   localparam int REPORT_LIMIT    = 10;

   localparam longint unsigned MAG_LIMIT = 64'(nsfp_pkg::VALUE_LIMIT);
   localparam longint unsigned TEN_POW [0:7] = '{
      64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000, 64'd10000000
   };

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_PRINT_LO = 8'h21;
   localparam logic [7:0] CH_PRINT_HI = 8'h7E;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_CR      = 8'h0D;

   typedef enum logic [2:0] {
      K_GGA, K_RMC, K_GLL, K_VTG, K_GSA, K_GSV, K_ZDA, K_UNKNOWN
   } sentence_kind_type;

   typedef enum logic [4:0] {
      Q_FIX_TIME, Q_LAT, Q_LAT_DIR, Q_LON, Q_LON_DIR, Q_FIX_QUALITY, Q_SAT_COUNT, Q_HDOP,
      Q_ALTITUDE, Q_STATUS, Q_SPEED_KNOTS, Q_TRACK, Q_MAG_VAR, Q_MAG_VAR_DIR, Q_TRUE_TRACK,
      Q_MAG_TRACK, Q_SPEED_KMH, Q_OP_MODE, Q_SENTENCE_NUM, Q_SATS_IN_VIEW, Q_UTC_TIME,
      Q_DAY, Q_MONTH, Q_YEAR, Q_NONE = 5'd31
   } quantity_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_SLOW} rx_mode_type;

   // Three type letters per sentence kind, in kind order.
   localparam logic [23:0] KIND_NAME [0:6] = '{"GGA", "RMC", "GLL", "VTG", "GSA", "GSV", "ZDA"};

   // Which quantity each field of each kind carries; field 0 is the address field.
   localparam quantity_type FIELD_QTY [0:6][0:FIELD_SLOTS-1] = '{
      '{Q_NONE, Q_FIX_TIME, Q_LAT, Q_LAT_DIR, Q_LON, Q_LON_DIR, Q_FIX_QUALITY, Q_SAT_COUNT,
        Q_HDOP, Q_ALTITUDE, Q_NONE, Q_NONE},
      '{Q_NONE, Q_FIX_TIME, Q_STATUS, Q_LAT, Q_LAT_DIR, Q_LON, Q_LON_DIR, Q_SPEED_KNOTS,
        Q_TRACK, Q_NONE, Q_MAG_VAR, Q_MAG_VAR_DIR},
      '{Q_NONE, Q_LAT, Q_LAT_DIR, Q_LON, Q_LON_DIR, Q_STATUS, Q_NONE, Q_NONE,
        Q_NONE, Q_NONE, Q_NONE, Q_NONE},
      '{Q_NONE, Q_TRUE_TRACK, Q_MAG_TRACK, Q_SPEED_KNOTS, Q_SPEED_KMH, Q_NONE, Q_NONE,
        Q_NONE, Q_NONE, Q_NONE, Q_NONE, Q_NONE},
      '{Q_NONE, Q_OP_MODE, Q_NONE, Q_NONE, Q_NONE, Q_NONE, Q_NONE, Q_NONE,
        Q_NONE, Q_NONE, Q_NONE, Q_NONE},
      '{Q_NONE, Q_NONE, Q_SENTENCE_NUM, Q_SATS_IN_VIEW, Q_NONE, Q_NONE, Q_NONE, Q_NONE,
        Q_NONE, Q_NONE, Q_NONE, Q_NONE},
      '{Q_NONE, Q_UTC_TIME, Q_DAY, Q_MONTH, Q_YEAR, Q_NONE, Q_NONE, Q_NONE,
        Q_NONE, Q_NONE, Q_NONE, Q_NONE}
   };

   // Real, integer or character, indexed by quantity code.
   localparam nsfp_pkg::qty_class_type QTY_CLASS_OF [0:23] = '{
      nsfp_pkg::QT_INT,  nsfp_pkg::QT_REAL, nsfp_pkg::QT_CHAR, nsfp_pkg::QT_REAL,
      nsfp_pkg::QT_CHAR, nsfp_pkg::QT_INT,  nsfp_pkg::QT_INT,  nsfp_pkg::QT_REAL,
      nsfp_pkg::QT_REAL, nsfp_pkg::QT_CHAR, nsfp_pkg::QT_REAL, nsfp_pkg::QT_REAL,
      nsfp_pkg::QT_REAL, nsfp_pkg::QT_CHAR, nsfp_pkg::QT_REAL, nsfp_pkg::QT_REAL,
      nsfp_pkg::QT_REAL, nsfp_pkg::QT_CHAR, nsfp_pkg::QT_INT,  nsfp_pkg::QT_INT,
      nsfp_pkg::QT_INT,  nsfp_pkg::QT_INT,  nsfp_pkg::QT_INT,  nsfp_pkg::QT_INT
   };

   typedef struct packed {
      logic [2:0]         kind;
      logic [4:0]         qty;
      logic signed [47:0] value;
      logic [7:0]         first_ch;
      logic               eos;
   } field_word_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [2:0]  rsp_sentence_kind;
   logic [4:0]  rsp_quantity_code;
   logic signed [47:0] rsp_scaled_value;
   logic [7:0]  rsp_first_char;
   logic        rsp_end_of_sentence;

   nmea_sentence_field_parser u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sentence_kind  (rsp_sentence_kind),
      .rsp_quantity_code  (rsp_quantity_code),
      .rsp_scaled_value   (rsp_scaled_value),
      .rsp_first_char     (rsp_first_char),
      .rsp_end_of_sentence(rsp_end_of_sentence)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Parser shadow state: mirrors the sentence and field trackers of the block.
   // ---------------------------------------------------------------------------------
   logic [2:0]        pos_count;
   sentence_kind_type kind_now;
   logic [7:0]        type_hi, type_lo;
   logic [4:0]        field_idx;
   longint unsigned   mag_acc;
   logic [2:0]        frac_seen;
   logic              is_neg, has_point, num_stopped, num_started;
   logic [7:0]        first_seen;
   logic [4:0]        chars_seen;

   field_word_type   pending_fields[$];
   int               mismatch_count = 0;
   int               sent_count     = 0;
   int               quiet_cycles   = 0;
   int               burst_left     = 0;
   bit               pacing_on      = 1'b1;

   function automatic void clear_field();
      mag_acc     = 0;
      frac_seen   = '0;
      is_neg      = 1'b0;
      has_point   = 1'b0;
      num_stopped = 1'b0;
      num_started = 1'b0;
      first_seen  = '0;
      chars_seen  = '0;
   endfunction

   function automatic void rearm_parser();
      pos_count = '0;
      kind_now  = K_UNKNOWN;
      type_hi   = '0;
      type_lo   = '0;
      field_idx = '0;
      clear_field();
   endfunction

   function automatic longint unsigned clamp_mag(input longint unsigned m);
      return (m > MAG_LIMIT) ? MAG_LIMIT : m;
   endfunction

   // Advance the shadow parser by one character; return 1 when a word is due.
   function automatic bit parse_char(input logic [7:0] c, output field_word_type w);
      quantity_type     q;
      longint unsigned  mag, signed_mag, digit;
      bit               hit;
      w   = '0;
      hit = 1'b0;
      // Newline or NUL: emit the end marker and start over.
      if (c == nsfp_pkg::CH_NEWLINE || c == nsfp_pkg::CH_NUL) begin
         w.eos = 1'b1;
         rearm_parser();
         return 1'b1;
      end
      // Latch the type letters; the third one decides the kind.
      case (pos_count)
         3'd3: type_hi = c;
         3'd4: type_lo = c;
         3'd5: begin
            kind_now = K_UNKNOWN;
            for (int k = 0; k < 7; k++) begin
               if (KIND_NAME[k] == {type_hi, type_lo, c} && kind_now == K_UNKNOWN)
                  kind_now = sentence_kind_type'(k);
            end
         end
         default: ;
      endcase
      if (pos_count < POS_TOP) pos_count++;

      if (c == nsfp_pkg::CH_COMMA) begin
         if (kind_now != K_UNKNOWN && field_idx < FIELD_SLOTS) begin
            q = FIELD_QTY[kind_now][field_idx];
            if (q != Q_NONE) begin
               mag = mag_acc;
               if (QTY_CLASS_OF[q] == nsfp_pkg::QT_INT)
                  mag = (mag / TEN_POW[FRAC_DIGITS]) * TEN_POW[FRAC_DIGITS];
               else if (QTY_CLASS_OF[q] == nsfp_pkg::QT_CHAR)
                  mag = 0;
               signed_mag = is_neg ? (64'd0 - mag) : mag;
               w.kind     = kind_now;
               w.qty      = q;
               w.value    = signed_mag[47:0];
               w.first_ch = first_seen;
               hit        = 1'b1;
            end
         end
         clear_field();
         if (field_idx < FIELD_NUM_TOP) field_idx++;
         return hit;
      end

      // Characters past the field length cap are dropped.
      if (chars_seen < MAX_FIELD_CHARS) begin
         if (chars_seen == 0) first_seen = c;
         if (!num_stopped) begin
            if ((c == nsfp_pkg::CH_MINUS || c == nsfp_pkg::CH_PLUS) && !num_started) begin
               if (c == nsfp_pkg::CH_MINUS) is_neg = 1'b1;
               num_started = 1'b1;
            end else if (c >= nsfp_pkg::CH_ZERO && c <= nsfp_pkg::CH_NINE) begin
               digit       = 64'(c - nsfp_pkg::CH_ZERO);
               num_started = 1'b1;
               if (!has_point) begin
                  mag_acc = clamp_mag(mag_acc * 10 + digit * TEN_POW[FRAC_DIGITS]);
               end else if (frac_seen < FRAC_DIGITS) begin
                  mag_acc   = clamp_mag(mag_acc + digit * TEN_POW[FRAC_DIGITS - 1 - frac_seen]);
                  frac_seen++;
               end
            end else if (c == nsfp_pkg::CH_POINT && !has_point) begin
               has_point   = 1'b1;
               num_started = 1'b1;
            end else begin
               num_stopped = 1'b1;
            end
         end
         chars_seen++;
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------------------
   // Sender: one character per word, in bursts with random gaps.
   // ---------------------------------------------------------------------------------
   task automatic send_char(input logic [7:0] c);
      int             gap;
      field_word_type w;
      @(negedge clock);
      if (burst_left == 0) begin
         // Pick the next burst; about one burst in four runs back to back.
         burst_left = $urandom_range(1, 40);
         pacing_on  = ($urandom_range(0, 3) != 0);
         gap        = pacing_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= c;
      // Hold the word until the block takes it.
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (parse_char(c, w)) pending_fields.push_back(w);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   // Drop valid and hold off until every predicted word has come back.
   task automatic drain_outputs();
      @(negedge clock);
      req_valid  <= 1'b0;
      burst_left = 0;
      while (pending_fields.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // Receiver: stall in phases of its own - open, coin toss, rotating pattern, slow.
   // ---------------------------------------------------------------------------------
   rx_mode_type rx_mode    = RX_OPEN;
   int          rx_left    = 0;
   logic [15:0] stall_bits = 16'h0001;

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode    = rx_mode_type'($urandom_range(0, 3));
         rx_left    = $urandom_range(20, 150);
         stall_bits = 16'($urandom) | 16'h0001;
      end
      rx_left--;
      stall_bits = {stall_bits[14:0], stall_bits[15]};
      case (rx_mode)
         RX_OPEN:    rsp_ready <= 1'b1;
         RX_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
         RX_PATTERN: rsp_ready <= stall_bits[0];
         default:    rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Checker: compare each accepted word field by field with the oldest prediction.
   // ---------------------------------------------------------------------------------
   task automatic report_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   task automatic check_field(input string label, input longint want, input longint got);
      if (want != got)
         report_error($sformatf("%s mismatch: expected %0d, got %0d", label, want, got));
   endtask

   always @(posedge clock) begin
      field_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_fields.size() == 0) begin
            report_error($sformatf("word with nothing pending: kind %0d qty %0d value %0d eos %0d",
                                   rsp_sentence_kind, rsp_quantity_code, rsp_scaled_value,
                                   rsp_end_of_sentence));
         end else begin
            want = pending_fields.pop_front();
            check_field("sentence_kind", want.kind, rsp_sentence_kind);
            check_field("quantity_code", want.qty, rsp_quantity_code);
            check_field("scaled_value", $signed(want.value), $signed(rsp_scaled_value));
            check_field("first_char", want.first_ch, rsp_first_char);
            check_field("end_of_sentence", want.eos, rsp_end_of_sentence);
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // End markers on an idle parser, and a comma before the kind is known.
   task automatic test_end_markers();
      send_char(nsfp_pkg::CH_NUL);
      send_char(nsfp_pkg::CH_COMMA);
      send_char(nsfp_pkg::CH_NEWLINE);
   endtask

   // GGA with a negative integer quantity (fraction dropped), a saturating latitude
   // and a character field whose first byte has every bit set.
   task automatic test_gga_extremes();
      send_text("$GPGGA,-9.5,9999999999,");
      send_char(8'hFF);
      send_char(nsfp_pkg::CH_COMMA);
      send_char(nsfp_pkg::CH_NEWLINE);
   endtask

   // Mostly well-formed sentences with random field contents, plus raw noise,
   // near-miss type names and sentences cut short.
   task automatic test_random_sentences();
      logic [7:0]  line_q[$];
      logic [23:0] name;
      int          start_count, n_fields, style, n, sign_pick, pause_at;
      start_count = sent_count;
      while (sent_count - start_count < RANDOM_ITEMS) begin
         line_q.delete();
         if ($urandom_range(0, 9) == 0) begin
            // Raw noise: any byte, terminators and commas included.
            n = $urandom_range(1, 8);
            repeat (n) line_q.push_back(8'($urandom));
         end else begin
            line_q.push_back(CH_DOLLAR);
            repeat (2) line_q.push_back(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
            n = $urandom_range(0, 19);
            if (n < 17)
               name = KIND_NAME[$urandom_range(0, 6)];
            else if (n == 17)
               name = KIND_NAME[$urandom_range(0, 6)] ^ (24'h1 << $urandom_range(0, 23));
            else
               name = {8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)),
                       8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)),
                       8'($urandom_range(CH_UPPER_A, CH_UPPER_Z))};
            line_q.push_back(name[23:16]);
            line_q.push_back(name[15:8]);
            line_q.push_back(name[7:0]);

            n_fields = $urandom_range(0, 14);
            repeat (n_fields) begin
               style = $urandom_range(0, 9);
               case (style)
                  0: ;
                  1, 2, 3: begin
                     sign_pick = $urandom_range(0, 3);
                     if (sign_pick == 1) line_q.push_back(nsfp_pkg::CH_MINUS);
                     if (sign_pick == 2) line_q.push_back(nsfp_pkg::CH_PLUS);
                     repeat ($urandom_range(0, 6))
                        line_q.push_back(8'(nsfp_pkg::CH_ZERO + $urandom_range(0, 9)));
                     if ($urandom_range(0, 1)) begin
                        line_q.push_back(nsfp_pkg::CH_POINT);
                        repeat ($urandom_range(0, 8))
                           line_q.push_back(8'(nsfp_pkg::CH_ZERO + $urandom_range(0, 9)));
                     end
                  end
                  4: begin
                     // Big enough to saturate.
                     if ($urandom_range(0, 1)) line_q.push_back(nsfp_pkg::CH_MINUS);
                     repeat ($urandom_range(12, 20))
                        line_q.push_back(8'(nsfp_pkg::CH_ZERO + $urandom_range(0, 9)));
                  end
                  5: line_q.push_back(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
                  6: begin
                     // Long field: the digits after the length cap must not count.
                     repeat ($urandom_range(18, 24)) line_q.push_back(nsfp_pkg::CH_ZERO);
                     repeat ($urandom_range(1, 8))
                        line_q.push_back(8'(nsfp_pkg::CH_ZERO + $urandom_range(0, 9)));
                  end
                  7: repeat ($urandom_range(1, 4))
                        line_q.push_back(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
                  8: begin
                     repeat ($urandom_range(1, 4))
                        line_q.push_back(8'(nsfp_pkg::CH_ZERO + $urandom_range(0, 9)));
                     line_q.push_back(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
                     repeat ($urandom_range(1, 4))
                        line_q.push_back(8'(nsfp_pkg::CH_ZERO + $urandom_range(0, 9)));
                  end
                  default: begin
                     // Second sign or second point stops the number.
                     sign_pick = $urandom_range(0, 2);
                     line_q.push_back(sign_pick == 0 ? nsfp_pkg::CH_MINUS :
                                      sign_pick == 1 ? nsfp_pkg::CH_PLUS : nsfp_pkg::CH_POINT);
                     repeat ($urandom_range(0, 3))
                        line_q.push_back(8'(nsfp_pkg::CH_ZERO + $urandom_range(0, 9)));
                     sign_pick = $urandom_range(0, 2);
                     line_q.push_back(sign_pick == 0 ? nsfp_pkg::CH_MINUS :
                                      sign_pick == 1 ? nsfp_pkg::CH_PLUS : nsfp_pkg::CH_POINT);
                     repeat ($urandom_range(0, 3))
                        line_q.push_back(8'(nsfp_pkg::CH_ZERO + $urandom_range(0, 9)));
                  end
               endcase
               line_q.push_back(nsfp_pkg::CH_COMMA);
            end

            // Unterminated last field: checksum, a stray number or nothing.
            n = $urandom_range(0, 3);
            if (n < 2) begin
               line_q.push_back(CH_STAR);
               repeat (2) begin
                  sign_pick = $urandom_range(0, 15);
                  line_q.push_back(sign_pick < 10 ? 8'(nsfp_pkg::CH_ZERO + sign_pick)
                                                  : 8'(CH_UPPER_A + sign_pick - 10));
               end
            end else if (n == 2) begin
               repeat ($urandom_range(1, 5))
                  line_q.push_back(8'(nsfp_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
            n = $urandom_range(0, 9);
            if (n == 8) line_q.push_back(CH_CR);
            line_q.push_back(n == 9 ? nsfp_pkg::CH_NUL : nsfp_pkg::CH_NEWLINE);

            // Now and then cut the sentence short.
            if ($urandom_range(0, 9) == 0) begin
               n = $urandom_range(1, line_q.size());
               line_q = line_q[0:n-1];
               line_q.push_back(nsfp_pkg::CH_NEWLINE);
            end
         end

         // Occasionally stop mid-sentence until every word is back.
         pause_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, line_q.size() - 1) : -1;
         foreach (line_q[i]) begin
            if (i == pause_at) drain_outputs();
            send_char(line_q[i]);
         end
      end
   endtask

   initial begin
      rearm_parser();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_end_markers();
      test_gga_extremes();
      drain_outputs();
      test_random_sentences();
      drain_outputs();

      // Let any stray word surface before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_fields.size() != 0) report_error("predicted words never arrived");
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/nsfp_pkg.sv
src/nsfp_front.sv
src/nsfp_queue.sv
src/nsfp_back.sv
src/nmea_sentence_field_parser.sv
tb/tb_nmea_sentence_field_parser.sv
